FILE: rtl/gtp_pkg.sv
package gtp_pkg;

  // Number of CORDIC micro-rotations per run.
  localparam int CordicSteps   = 16;
  // Fraction bits of the external angle format.
  localparam int AngleFracBits = 7;
  // Internal CORDIC angles are degrees in Q16.
  localparam int CordicFrac    = 16;
  localparam int AngleShift    = CordicFrac - AngleFracBits;

  localparam int StepW  = 5;
  localparam int AngleW = 26;
  localparam int VecW   = 35;

  // Angle constants in the external angle format.
  localparam int Deg90Q  = 90 << AngleFracBits;
  localparam int Deg180Q = 180 << AngleFracBits;
  localparam int Deg360Q = 360 << AngleFracBits;
  // Constants in Q16 degrees.
  localparam int Deg180Z = 180 << CordicFrac;

  // Initial x of the sine/cosine rotation: 1/K in Q30.
  localparam longint SinCosX0 = 64'd652032874;
  // Pre-scale of atan2 operands.
  localparam int VecShift = 14;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ARRIVE_RADIUS = 3'd0,
    CFG_BEARING_KP    = 3'd1,
    CFG_BEARING_KD    = 3'd2,
    CFG_HEADING_KP    = 3'd3,
    CFG_HEADING_KD    = 3'd4,
    CFG_COMMAND_LIMIT = 3'd5
  } cfg_idx_e;

  // Arctangent of 2^-i in Q16 degrees.
  function automatic logic signed [AngleW-1:0] atan_tab(input logic [StepW-1:0] i);
    logic signed [AngleW-1:0] r;
    case (i)
      5'd0:  r = 26'sd2949120;
      5'd1:  r = 26'sd1740967;
      5'd2:  r = 26'sd919879;
      5'd3:  r = 26'sd466945;
      5'd4:  r = 26'sd234379;
      5'd5:  r = 26'sd117304;
      5'd6:  r = 26'sd58666;
      5'd7:  r = 26'sd29335;
      5'd8:  r = 26'sd14668;
      5'd9:  r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/go_to_point_pd_controller_core.sv
// One tick runs three 16-step CORDIC runs on one shared rotation unit, ten multiplier
// passes and an 8-step angle wrap; when the tick ends arrived, the PD, wrap and sine/cosine
// steps are skipped. The input stalls while an item is in work, and a finished result waits
// in the output register without blocking the next input.
// Reset (rst_ni low, asynchronous) restores register defaults and clears the controller state.
module go_to_point_pd_controller_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [25:0]        cfg_data_i,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [16:0] robot_heading_i,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  input  logic signed [16:0] goal_heading_i,
  input  logic [9:0]         speed_i,
  input  logic               capture_start_i,
  // Output channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] cmd_x_o,
  output logic signed [15:0] cmd_y_o,
  output logic signed [15:0] cmd_turn_o,
  output logic               arrived_o
);

  localparam int VW = gtp_pkg::VecW;
  localparam int AW = gtp_pkg::AngleW;

  // The sequencer walks through the steps of one tick. Each multiplier step loads the
  // product register; the step after it consumes the product.
  typedef enum logic [4:0] {
    ST_IDLE, ST_D2A, ST_D2B, ST_D2C, ST_D2D,
    ST_AT_INIT, ST_AT_ITER, ST_AT_DONE, ST_ERR,
    ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
    ST_WR0, ST_WR, ST_FOLD, ST_SC_ITER,
    ST_O1, ST_O2, ST_O3, ST_O4, ST_DONE
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [9:0]  radius_q;
  logic [25:0] bkp_q, bkd_q, hkp_q, hkd_q;
  logic [14:0] limit_q;

  // Captured tick inputs.
  logic signed [15:0] px_q, py_q, gx_q, gy_q;
  logic signed [16:0] rh_q, gh_q;
  logic [9:0]         spd_q;

  // Persistent state.
  logic signed [15:0] start_x_q, start_y_q;
  logic signed [17:0] prev_be_q, prev_he_q;
  logic               arrived_q;

  // Working registers.
  logic signed [60:0] prod_q;
  logic signed [46:0] acc_q;
  logic               d2le_q;
  logic               pass_q;
  logic               zvec_q;
  logic               neg_q;
  logic signed [17:0] bt_q, br_q;
  logic signed [17:0] be_q, he_q;
  logic signed [18:0] dbe_q, dhe_q;
  logic signed [22:0] pb_q, ph_q;
  logic signed [24:0] wrap_q;
  logic [2:0]         k_q;
  logic signed [VW-1:0] x_q, y_q;
  logic signed [AW-1:0] z_q;
  logic [gtp_pkg::StepW-1:0] it_q;
  logic signed [15:0] cx_q, cy_q, ct_q;

  // Output register.
  logic               out_valid_q;
  logic signed [15:0] out_cx_q, out_cy_q, out_ct_q;
  logic               out_arr_q;

  // Clamps v to the symmetric range given by lim.
  function automatic logic signed [60:0] sat(input logic signed [60:0] v,
                                             input logic signed [60:0] lim);
    logic signed [60:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic in_take;
  logic out_free;
  assign in_take  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_x_o     = out_cx_q;
  assign cmd_y_o     = out_cy_q;
  assign cmd_turn_o  = out_ct_q;
  assign arrived_o   = out_arr_q;

  // Headings are limited to plus or minus one full turn.
  logic signed [16:0] rh_in, gh_in;
  always_comb begin
    rh_in = robot_heading_i;
    if (robot_heading_i > 17'(gtp_pkg::Deg360Q)) begin
      rh_in = 17'(gtp_pkg::Deg360Q);
    end else if (robot_heading_i < -17'(gtp_pkg::Deg360Q)) begin
      rh_in = -17'(gtp_pkg::Deg360Q);
    end
    gh_in = goal_heading_i;
    if (goal_heading_i > 17'(gtp_pkg::Deg360Q)) begin
      gh_in = 17'(gtp_pkg::Deg360Q);
    end else if (goal_heading_i < -17'(gtp_pkg::Deg360Q)) begin
      gh_in = -17'(gtp_pkg::Deg360Q);
    end
  end

  logic signed [16:0] ex, ey;
  assign ex = 17'(gx_q) - 17'(px_q);
  assign ey = 17'(gy_q) - 17'(py_q);

  // Shared multiplier; its operands are chosen by the sequencer step.
  logic signed [33:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [60:0] mul_p;
  logic signed [VW-1:0] sin_v, cos_v;

  assign sin_v = neg_q ? -y_q : y_q;
  assign cos_v = neg_q ? -x_q : x_q;

  always_comb begin
    mul_a = 34'sd0;
    mul_b = 27'sd0;
    case (state_q)
      ST_D2A: begin
        mul_a = 34'(ex);
        mul_b = 27'(ex);
      end
      ST_D2B: begin
        mul_a = 34'(ey);
        mul_b = 27'(ey);
      end
      ST_D2C: begin
        mul_a = 34'(signed'({1'b0, radius_q}));
        mul_b = 27'(signed'({1'b0, radius_q}));
      end
      ST_P1: begin
        mul_a = 34'(be_q);
        mul_b = signed'({1'b0, bkp_q});
      end
      ST_P2: begin
        mul_a = 34'(dbe_q);
        mul_b = signed'({1'b0, bkd_q});
      end
      ST_P4: begin
        mul_a = 34'(he_q);
        mul_b = signed'({1'b0, hkp_q});
      end
      ST_P5: begin
        mul_a = 34'(dhe_q);
        mul_b = signed'({1'b0, hkd_q});
      end
      ST_O1: begin
        mul_a = 34'(sin_v);
        mul_b = 27'(signed'({1'b0, spd_q}));
      end
      ST_O2: begin
        mul_a = 34'(cos_v);
        mul_b = 27'(signed'({1'b0, spd_q}));
      end
      ST_O3: begin
        mul_a = 34'(ph_q);
        mul_b = 27'(signed'({1'b0, spd_q}));
      end
      default: begin
        mul_a = 34'sd0;
        mul_b = 27'sd0;
      end
    endcase
  end

  assign mul_p = 61'(mul_a) * 61'(mul_b);

  // Shared CORDIC rotation step. In vectoring mode the sign of y picks the direction,
  // in rotation mode the sign of the residual angle does.
  logic signed [VW-1:0] shx, shy, x_n, y_n;
  logic signed [AW-1:0] tab, z_n;
  logic                 dir;
  always_comb begin
    shx = x_q >>> it_q;
    shy = y_q >>> it_q;
    tab = gtp_pkg::atan_tab(it_q);
    if (state_q == ST_SC_ITER) begin
      dir = !z_q[AW-1];
      x_n = dir ? x_q - shy : x_q + shy;
      y_n = dir ? y_q + shx : y_q - shx;
      z_n = dir ? z_q - tab : z_q + tab;
    end else begin
      dir = !y_q[VW-1];
      x_n = dir ? x_q + shy : x_q - shy;
      y_n = dir ? y_q - shx : y_q + shx;
      z_n = dir ? z_q + tab : z_q - tab;
    end
  end

  // Vectoring start: bearing from the segment start on the first pass, from the
  // robot on the second.
  logic signed [16:0] num, den;
  assign num = pass_q ? ex : 17'(gx_q) - 17'(start_x_q);
  assign den = pass_q ? ey : 17'(gy_q) - 17'(start_y_q);

  // Angle in Q7, rounded half up.
  logic signed [AW-1:0] zq;
  logic signed [17:0]   z_q7;
  assign zq   = zvec_q ? '0 : z_q;
  assign z_q7 = 18'((zq + AW'(1 << (gtp_pkg::AngleShift - 1))) >>> gtp_pkg::AngleShift);

  // Error terms of this tick.
  logic signed [17:0] be_c, he_c;
  logic               flag_keep;
  assign be_c = bt_q - br_q;
  assign he_c = 18'(gh_q) - 18'(rh_q);
  assign flag_keep = arrived_q && !(br_q > 18'sd0);

  // PD rounding and limit.
  logic signed [60:0] limq, lim61;
  logic signed [60:0] pd_sum, pd_rnd;
  assign limq   = 61'(signed'({1'b0, limit_q})) <<< gtp_pkg::AngleFracBits;
  assign lim61  = 61'(signed'({1'b0, limit_q}));
  assign pd_sum = 61'(acc_q) + prod_q;
  assign pd_rnd = sat((61'(acc_q) + 61'sd32768) >>> 16, limq);

  // Products of speed with a Q30 sine or cosine and with the Q7 heading term, back to integer.
  logic signed [60:0] trig_rnd, turn_rnd;
  assign trig_rnd = sat((prod_q + 61'sd536870912) >>> 30, lim61);
  assign turn_rnd = sat((-prod_q + 61'(1 << (gtp_pkg::AngleFracBits - 1)))
                        >>> gtp_pkg::AngleFracBits, lim61);

  // Angle wrap of the steering direction into one half-open turn.
  logic signed [23:0] steer;
  logic signed [24:0] wrap0, wrap_sub, fold_s;
  assign steer    = 24'(bt_q) - 24'(pb_q);
  assign wrap0    = 25'(steer) + 25'(gtp_pkg::Deg180Q);
  assign wrap_sub = 25'(gtp_pkg::Deg360Q) <<< k_q;
  assign fold_s   = wrap_q - 25'(gtp_pkg::Deg180Q);

  logic last_step;
  assign last_step = (it_q == gtp_pkg::StepW'(gtp_pkg::CordicSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= 10'd10;
      bkp_q       <= 26'd786432;
      bkd_q       <= 26'd3276800;
      hkp_q       <= 26'd655;
      hkd_q       <= 26'd131072;
      limit_q     <= 15'd1000;
      start_x_q   <= '0;
      start_y_q   <= '0;
      prev_be_q   <= '0;
      prev_he_q   <= '0;
      arrived_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          gtp_pkg::CFG_ARRIVE_RADIUS: radius_q <= cfg_data_i[9:0];
          gtp_pkg::CFG_BEARING_KP:    bkp_q    <= cfg_data_i;
          gtp_pkg::CFG_BEARING_KD:    bkd_q    <= cfg_data_i;
          gtp_pkg::CFG_HEADING_KP:    hkp_q    <= cfg_data_i;
          gtp_pkg::CFG_HEADING_KD:    hkd_q    <= cfg_data_i;
          gtp_pkg::CFG_COMMAND_LIMIT: limit_q  <= cfg_data_i[14:0];
          default: ;
        endcase
      end

      // The output register fills from the last step and empties on a transfer.
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            px_q  <= pos_x_i;
            py_q  <= pos_y_i;
            gx_q  <= goal_x_i;
            gy_q  <= goal_y_i;
            rh_q  <= rh_in;
            gh_q  <= gh_in;
            spd_q <= speed_i;
            if (capture_start_i) begin
              start_x_q <= pos_x_i;
              start_y_q <= pos_y_i;
            end
            state_q <= ST_D2A;
          end
        end
        ST_D2A: begin
          prod_q  <= mul_p;
          state_q <= ST_D2B;
        end
        ST_D2B: begin
          acc_q   <= 47'(prod_q);
          prod_q  <= mul_p;
          state_q <= ST_D2C;
        end
        ST_D2C: begin
          acc_q   <= 47'(pd_sum);
          prod_q  <= mul_p;
          state_q <= ST_D2D;
        end
        ST_D2D: begin
          // Squared distance against squared radius.
          d2le_q  <= (61'(acc_q) <= prod_q);
          pass_q  <= 1'b0;
          state_q <= ST_AT_INIT;
        end
        ST_AT_INIT: begin
          zvec_q <= (num == 17'sd0) && (den == 17'sd0);
          it_q   <= '0;
          if (den < 17'sd0) begin
            // Left half plane: pre-rotate by half a turn.
            x_q <= -(VW'(den) <<< gtp_pkg::VecShift);
            y_q <= -(VW'(num) <<< gtp_pkg::VecShift);
            z_q <= (num >= 17'sd0) ? AW'(gtp_pkg::Deg180Z) : -AW'(gtp_pkg::Deg180Z);
          end else begin
            x_q <= VW'(den) <<< gtp_pkg::VecShift;
            y_q <= VW'(num) <<< gtp_pkg::VecShift;
            z_q <= '0;
          end
          state_q <= ST_AT_ITER;
        end
        ST_AT_ITER: begin
          x_q  <= x_n;
          y_q  <= y_n;
          z_q  <= z_n;
          it_q <= it_q + 1'b1;
          if (last_step) begin
            state_q <= ST_AT_DONE;
          end
        end
        ST_AT_DONE: begin
          if (!pass_q) begin
            bt_q    <= z_q7;
            pass_q  <= 1'b1;
            state_q <= ST_AT_INIT;
          end else begin
            br_q    <= z_q7;
            state_q <= ST_ERR;
          end
        end
        ST_ERR: begin
          // Both stored errors move on every tick, arrived or not.
          be_q      <= be_c;
          he_q      <= he_c;
          dbe_q     <= 19'(be_c) - 19'(prev_be_q);
          dhe_q     <= 19'(he_c) - 19'(prev_he_q);
          prev_be_q <= be_c;
          prev_he_q <= he_c;
          cx_q      <= '0;
          cy_q      <= '0;
          ct_q      <= '0;
          if (d2le_q) begin
            arrived_q <= 1'b1;
            state_q   <= ST_DONE;
          end else begin
            // Outside the radius the flag drops only once the goal bearing is positive.
            arrived_q <= flag_keep;
            state_q   <= flag_keep ? ST_DONE : ST_P1;
          end
        end
        ST_P1: begin
          prod_q  <= mul_p;
          state_q <= ST_P2;
        end
        ST_P2: begin
          acc_q   <= 47'(prod_q);
          prod_q  <= mul_p;
          state_q <= ST_P3;
        end
        ST_P3: begin
          acc_q   <= 47'(pd_sum);
          state_q <= ST_P4;
        end
        ST_P4: begin
          pb_q    <= 23'(pd_rnd);
          prod_q  <= mul_p;
          state_q <= ST_P5;
        end
        ST_P5: begin
          acc_q   <= 47'(prod_q);
          prod_q  <= mul_p;
          state_q <= ST_P6;
        end
        ST_P6: begin
          acc_q   <= 47'(pd_sum);
          state_q <= ST_P7;
        end
        ST_P7: begin
          ph_q    <= 23'(pd_rnd);
          state_q <= ST_WR0;
        end
        ST_WR0: begin
          // Offset by enough whole turns to make the value non-negative.
          wrap_q  <= (wrap0 < 25'sd0) ? wrap0 + (25'(gtp_pkg::Deg360Q) <<< 7) : wrap0;
          k_q     <= 3'd7;
          state_q <= ST_WR;
        end
        ST_WR: begin
          // Restoring reduction by one turn times a power of two per cycle.
          if (wrap_q >= wrap_sub) begin
            wrap_q <= wrap_q - wrap_sub;
          end
          k_q <= k_q - 1'b1;
          if (k_q == 3'd0) begin
            state_q <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          // Fold into the right half plane; the sign flip is applied to the result.
          if (fold_s > 25'(gtp_pkg::Deg90Q)) begin
            neg_q <= 1'b1;
            z_q   <= AW'(fold_s - 25'(gtp_pkg::Deg180Q)) <<< gtp_pkg::AngleShift;
          end else if (fold_s < -25'(gtp_pkg::Deg90Q)) begin
            neg_q <= 1'b1;
            z_q   <= AW'(fold_s + 25'(gtp_pkg::Deg180Q)) <<< gtp_pkg::AngleShift;
          end else begin
            neg_q <= 1'b0;
            z_q   <= AW'(fold_s) <<< gtp_pkg::AngleShift;
          end
          x_q     <= VW'(gtp_pkg::SinCosX0);
          y_q     <= '0;
          it_q    <= '0;
          state_q <= ST_SC_ITER;
        end
        ST_SC_ITER: begin
          x_q  <= x_n;
          y_q  <= y_n;
          z_q  <= z_n;
          it_q <= it_q + 1'b1;
          if (last_step) begin
            state_q <= ST_O1;
          end
        end
        ST_O1: begin
          prod_q  <= mul_p;
          state_q <= ST_O2;
        end
        ST_O2: begin
          cx_q    <= 16'(trig_rnd);
          prod_q  <= mul_p;
          state_q <= ST_O3;
        end
        ST_O3: begin
          cy_q    <= 16'(trig_rnd);
          prod_q  <= mul_p;
          state_q <= ST_O4;
        end
        ST_O4: begin
          ct_q    <= 16'(turn_rnd);
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_cx_q    <= cx_q;
            out_cy_q    <= cy_q;
            out_ct_q    <= ct_q;
            out_arr_q   <= arrived_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
